// ===== hdl/strm_pkg.sv =====
// Shared constants, command kinds and sizing helpers for the sparse table range-min block.
package strm_pkg;

    localparam int DEF_MAX_VALUES  = 1024;
    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    // Bits of one queued command: kind, last, write enable, load address,
    // value, count, and two table read addresses.
    function automatic int cmd_bits(input int idx_w, input int val_w, input int cnt_w,
                                    input int tab_aw);
        return $bits(kind_t) + 2 + idx_w + val_w + cnt_w + 2 * tab_aw;
    endfunction

endpackage

// ===== hdl/strm_front.sv =====
// Front end: accepts items, tracks the loaded count and classifies loads and queries.
module strm_front #(
    parameter int MAX_VALUES  = strm_pkg::DEF_MAX_VALUES,
    parameter int VALUE_WIDTH = strm_pkg::DEF_VALUE_WIDTH,
    localparam int IDX_W  = $clog2(MAX_VALUES),
    localparam int CNT_W  = $clog2(MAX_VALUES + 1),
    localparam int LEVELS = $clog2(MAX_VALUES + 1),
    localparam int TAB_AW = $clog2(LEVELS * MAX_VALUES),
    localparam int CMD_W  = strm_pkg::cmd_bits(IDX_W, VALUE_WIDTH, CNT_W, TAB_AW)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    input  logic                          s_last_value,
    input  logic        [IDX_W-1:0]       s_left,
    input  logic        [CNT_W-1:0]       s_right,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output logic        [CMD_W-1:0]       cmd_data
);
    import strm_pkg::*;

    localparam int LVL_W = $clog2(LEVELS);

    typedef struct packed {
        kind_t                  kind;
        logic                   last;
        logic                   we;
        logic [IDX_W-1:0]       waddr;
        logic [VALUE_WIDTH-1:0] value;
        logic [CNT_W-1:0]       count;
        logic [TAB_AW-1:0]      addr_a;
        logic [TAB_AW-1:0]      addr_b;
    } cmd_t;

    function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] x);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (x[i]) begin
                r = LVL_W'(i);
            end
        end
        return r;
    endfunction

    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] base;
    logic             has_room;
    logic             err;
    logic [CNT_W-1:0] len;
    logic [LVL_W-1:0] dep;
    logic [CNT_W-1:0] win_span;
    logic [IDX_W-1:0] pos_b;
    logic [TAB_AW-1:0] row_base;
    logic             accept;
    cmd_t             cmd;

    assign accept    = s_valid && cmd_ready;
    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;
    assign cmd_data  = cmd;

    assign base     = done_reg ? '0 : cnt_reg;
    assign has_room = base < CNT_W'(MAX_VALUES);

    assign err = !done_reg || (CNT_W'(s_left) >= s_right) || (s_right > cnt_reg);
    assign len = s_right - CNT_W'(s_left);
    assign dep = floor_log2(len);
    assign win_span = CNT_W'(1) << dep;
    assign pos_b    = IDX_W'(s_right - win_span);
    assign row_base = TAB_AW'(dep) * TAB_AW'(MAX_VALUES);

    always_comb begin
        cmd.kind   = KIND_LOAD;
        cmd.last   = s_last_value;
        cmd.we     = has_room;
        cmd.waddr  = base[IDX_W-1:0];
        cmd.value  = s_value;
        cmd.count  = base + CNT_W'(has_room);
        cmd.addr_a = row_base + TAB_AW'(s_left);
        cmd.addr_b = row_base + TAB_AW'(pos_b);
        if (s_op == OP_QUERY) begin
            cmd.kind = err ? KIND_REJECT : KIND_QUERY;
        end
    end

    always_comb begin
        done_next = done_reg;
        cnt_next  = cnt_reg;
        if (accept && s_op == OP_LOAD) begin
            done_next = s_last_value;
            cnt_next  = cmd.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_VALUES))
        else $error("loaded count beyond capacity");

    a_done_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> cnt_reg != '0)
        else $error("complete set with no values");

    a_window_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd.kind == KIND_QUERY) |-> cmd.addr_b >= cmd.addr_a)
        else $error("second window starts before first");

endmodule

// ===== hdl/strm_fifo.sv =====
// Small command queue between the front end and the table engine.
module strm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = strm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W:0]   wr_ptr_reg, rd_ptr_reg;
    logic             full, empty;
    logic             do_push, do_pop;

    assign empty      = wr_ptr_reg == rd_ptr_reg;
    assign full       = (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]) &&
                        (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]);
    assign push_ready = !full;
    assign pop_valid  = !empty;
    assign pop_data   = mem_reg[rd_ptr_reg[PTR_W-1:0]];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop_ready && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg[PTR_W-1:0]] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== hdl/strm_back.sv =====
// Table engine: holds the value and minimum tables, builds levels and answers queries.
module strm_back #(
    parameter int MAX_VALUES  = strm_pkg::DEF_MAX_VALUES,
    parameter int VALUE_WIDTH = strm_pkg::DEF_VALUE_WIDTH,
    localparam int IDX_W  = $clog2(MAX_VALUES),
    localparam int CNT_W  = $clog2(MAX_VALUES + 1),
    localparam int LEVELS = $clog2(MAX_VALUES + 1),
    localparam int TAB_AW = $clog2(LEVELS * MAX_VALUES),
    localparam int CMD_W  = strm_pkg::cmd_bits(IDX_W, VALUE_WIDTH, CNT_W, TAB_AW)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    input  logic        [CMD_W-1:0]       cmd_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic        [IDX_W-1:0]       m_min_index,
    output logic signed [VALUE_WIDTH-1:0] m_min_value,
    output logic                          m_range_error
);
    import strm_pkg::*;

    localparam int TAB_DEPTH = LEVELS * MAX_VALUES;

    typedef struct packed {
        kind_t                  kind;
        logic                   last;
        logic                   we;
        logic [IDX_W-1:0]       waddr;
        logic [VALUE_WIDTH-1:0] value;
        logic [CNT_W-1:0]       count;
        logic [TAB_AW-1:0]      addr_a;
        logic [TAB_AW-1:0]      addr_b;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]       pos;
        logic [VALUE_WIDTH-1:0] value;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_BUILD = 3'b010,
        ST_TURN  = 3'b100
    } state_t;

    // Row 0 holds the loaded values; row k holds the minimum of 2^k values.
    entry_t tab_mem [TAB_DEPTH];

    cmd_t              cmd;
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  span_reg, span_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [TAB_AW-1:0] prev_base_reg, prev_base_next;
    logic [TAB_AW-1:0] cur_base_reg, cur_base_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [TAB_AW-1:0] wr_addr_reg, wr_addr_next;
    logic              q_pend_reg, q_pend_next;
    entry_t            rd_a_reg, rd_b_reg;
    logic              m_valid_reg;
    logic [IDX_W-1:0]  m_index_reg;
    logic [VALUE_WIDTH-1:0] m_value_reg;
    logic              m_error_reg;

    logic              slot_free;
    logic              rej_take;
    entry_t            win;
    logic              tab_we;
    logic [TAB_AW-1:0] tab_waddr;
    entry_t            tab_wdata;
    logic [TAB_AW-1:0] rd_addr_a, rd_addr_b;
    logic [CNT_W-1:0]  j_wide;
    logic [CNT_W+1:0]  span_x4;

    assign cmd       = cmd_data;
    assign slot_free = !q_pend_reg && (!m_valid_reg || m_ready);
    assign win       = ($signed(rd_a_reg.value) < $signed(rd_b_reg.value)) ? rd_a_reg : rd_b_reg;
    assign j_wide    = CNT_W'(j_reg);
    assign span_x4   = {span_reg, 2'b00};

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        span_next      = span_reg;
        j_next         = j_reg;
        prev_base_next = prev_base_reg;
        cur_base_next  = cur_base_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        q_pend_next    = 1'b0;
        cmd_pop        = 1'b0;
        rej_take       = 1'b0;
        tab_we         = wr_pend_reg;
        tab_waddr      = wr_addr_reg;
        tab_wdata      = win;
        rd_addr_a      = cmd.addr_a;
        rd_addr_b      = cmd.addr_b;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        KIND_LOAD: begin
                            cmd_pop = 1'b1;
                            if (cmd.we) begin
                                tab_we          = 1'b1;
                                tab_waddr       = TAB_AW'(cmd.waddr);
                                tab_wdata.pos   = cmd.waddr;
                                tab_wdata.value = cmd.value;
                            end
                            if (cmd.last && cmd.count >= CNT_W'(2)) begin
                                state_next     = ST_BUILD;
                                n_next         = cmd.count;
                                span_next      = CNT_W'(1);
                                j_next         = '0;
                                prev_base_next = '0;
                                cur_base_next  = TAB_AW'(MAX_VALUES);
                            end
                        end
                        KIND_QUERY: begin
                            if (slot_free) begin
                                cmd_pop     = 1'b1;
                                q_pend_next = 1'b1;
                            end
                        end
                        KIND_REJECT: begin
                            if (slot_free) begin
                                cmd_pop  = 1'b1;
                                rej_take = 1'b1;
                            end
                        end
                        default: begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_BUILD: begin
                rd_addr_a    = prev_base_reg + TAB_AW'(j_reg);
                rd_addr_b    = prev_base_reg + TAB_AW'(j_wide + span_reg);
                wr_pend_next = 1'b1;
                wr_addr_next = cur_base_reg + TAB_AW'(j_reg);
                if (j_wide == n_reg - (span_reg << 1)) begin
                    state_next = ST_TURN;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_TURN: begin
                // last write of the level lands here before the next level reads it
                if (span_x4 <= {2'b00, n_reg}) begin
                    state_next     = ST_BUILD;
                    span_next      = span_reg << 1;
                    j_next         = '0;
                    prev_base_next = cur_base_reg;
                    cur_base_next  = cur_base_reg + TAB_AW'(MAX_VALUES);
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tab_we) begin
            tab_mem[tab_waddr] <= tab_wdata;
        end
        rd_a_reg <= tab_mem[rd_addr_a];
        rd_b_reg <= tab_mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        span_reg      <= span_next;
        j_reg         <= j_next;
        prev_base_reg <= prev_base_next;
        cur_base_reg  <= cur_base_next;
        wr_addr_reg   <= wr_addr_next;
        if (q_pend_reg) begin
            m_index_reg <= win.pos;
            m_value_reg <= win.value;
            m_error_reg <= 1'b0;
        end else if (rej_take) begin
            m_index_reg <= '0;
            m_value_reg <= '0;
            m_error_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wr_pend_reg <= 1'b0;
            q_pend_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wr_pend_reg <= wr_pend_next;
            q_pend_reg  <= q_pend_next;
            if (q_pend_reg || rej_take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_min_index   = m_index_reg;
    assign m_min_value   = m_value_reg;
    assign m_range_error = m_error_reg;

    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pend_reg |-> !m_valid_reg)
        else $error("query result would overwrite a waiting item");

    a_no_write_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !wr_pend_reg)
        else $error("table write pending while queries may read");

    a_build_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_BUILD |-> (j_wide + span_reg) < n_reg)
        else $error("build read past the loaded count");

endmodule

// ===== hdl/sparse_table_range_min.sv =====
// Sparse table range-minimum top level: front end, command queue and table engine.
// Queries: a result passes the command queue, the table read registers and the output
// registers (a rejected query skips the table read); no query is taken while one is in
// the table read, a result waits unaccepted or the table is built. Loads are popped in
// any idle cycle. After the last load of two or more values the table is built, one
// entry per cycle, a turn state after each level, in one memory (one write, two reads).
// Reset clears control state and the loaded count; the table is not cleared.
module sparse_table_range_min #(
    parameter int MAX_VALUES  = strm_pkg::DEF_MAX_VALUES,
    parameter int VALUE_WIDTH = strm_pkg::DEF_VALUE_WIDTH,
    parameter int QUEUE_DEPTH = strm_pkg::DEF_QUEUE_DEPTH,
    localparam int IDX_W = $clog2(MAX_VALUES),
    localparam int CNT_W = $clog2(MAX_VALUES + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    input  logic                          s_last_value,
    input  logic        [IDX_W-1:0]       s_left,
    input  logic        [CNT_W-1:0]       s_right,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic        [IDX_W-1:0]       m_min_index,
    output logic signed [VALUE_WIDTH-1:0] m_min_value,
    output logic                          m_range_error
);
    import strm_pkg::*;

    localparam int LEVELS = $clog2(MAX_VALUES + 1);
    localparam int TAB_AW = $clog2(LEVELS * MAX_VALUES);
    localparam int CMD_W  = cmd_bits(IDX_W, VALUE_WIDTH, CNT_W, TAB_AW);

    logic             push_valid, push_ready;
    logic [CMD_W-1:0] push_data;
    logic             pop_valid, pop_ready;
    logic [CMD_W-1:0] pop_data;

    strm_front #(
        .MAX_VALUES  (MAX_VALUES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_value      (s_value),
        .s_last_value (s_last_value),
        .s_left       (s_left),
        .s_right      (s_right),
        .cmd_valid    (push_valid),
        .cmd_ready    (push_ready),
        .cmd_data     (push_data)
    );

    strm_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    strm_back #(
        .MAX_VALUES  (MAX_VALUES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (pop_valid),
        .cmd_pop       (pop_ready),
        .cmd_data      (pop_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_min_index   (m_min_index),
        .m_min_value   (m_min_value),
        .m_range_error (m_range_error)
    );

endmodule

// ===== tb/testbench.sv =====
// Testbench for sparse_table_range_min: queued stimulus, clocked driver and monitor, min predictor.
module testbench;
    import strm_pkg::*;

    localparam int N_MAX        = 1024;
    localparam int VW           = 32;
    localparam int IDX_W        = 10;
    localparam int CNT_W        = 11;
    localparam int LEVELS       = 11;
    localparam int LIMIT_CYCLES = 1000000;

    typedef struct {
        logic                 op;
        logic signed [VW-1:0] value;
        logic                 last;
        logic [IDX_W-1:0]     left;
        logic [CNT_W-1:0]     right;
    } request_t;

    typedef struct {
        logic [IDX_W-1:0]     idx;
        logic signed [VW-1:0] val;
        logic                 err;
    } range_min_t;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic                 s_op          = 1'b0;
    logic signed [VW-1:0] s_value       = '0;
    logic                 s_last_value  = 1'b0;
    logic [IDX_W-1:0]     s_left        = '0;
    logic [CNT_W-1:0]     s_right       = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [IDX_W-1:0]     m_min_index;
    logic signed [VW-1:0] m_min_value;
    logic                 m_range_error;

    sparse_table_range_min #(
        .MAX_VALUES (N_MAX),
        .VALUE_WIDTH(VW)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_value      (s_value),
        .s_last_value (s_last_value),
        .s_left       (s_left),
        .s_right      (s_right),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_min_index  (m_min_index),
        .m_min_value  (m_min_value),
        .m_range_error(m_range_error)
    );

    request_t   queued_requests[$];
    range_min_t expected_minima[$];

    // predictor state
    logic signed [VW-1:0] model_vals [0:N_MAX-1];
    logic [IDX_W-1:0]     min_pos    [0:LEVELS-1][0:N_MAX-1];
    int                   model_count    = 0;
    bit                   model_complete = 1'b0;

    int  n_items       = 0;
    int  n_taken       = 0;
    int  n_errors      = 0;
    int  cycles        = 0;
    bit  sent_ok       = 1'b0;
    int  send_gap      = 0;
    int  stall_left    = 0;
    int  hold_left     = 0;
    bit  pressure_done = 1'b0;
    int  gen_count     = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int c;
        c = $urandom_range(0, 99);
        if (c < 60) return 0;
        if (c < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [IDX_W-1:0] pick_min_pos(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
        return (model_vals[a] < model_vals[b]) ? a : b;
    endfunction

    task automatic build_min_table();
        int lvl;
        int span;
        int j;
        for (j = 0; j < model_count; j++)
            min_pos[0][j] = IDX_W'(j);
        span = 1;
        for (lvl = 1; lvl < LEVELS && span * 2 <= model_count; lvl++) begin
            for (j = 0; j + span * 2 <= model_count; j++)
                min_pos[lvl][j] = pick_min_pos(min_pos[lvl-1][j], min_pos[lvl-1][j+span]);
            span = span * 2;
        end
    endtask

    task automatic predict_range_min(request_t r);
        range_min_t res;
        int l;
        int rr;
        int len;
        int dep;
        logic [IDX_W-1:0] pos;
        if (r.op == OP_LOAD) begin
            if (model_complete) begin
                model_count    = 0;
                model_complete = 1'b0;
            end
            if (model_count < N_MAX) begin
                model_vals[model_count] = r.value;
                model_count++;
            end
            if (r.last) begin
                model_complete = 1'b1;
                build_min_table();
            end
        end else begin
            l  = int'(r.left);
            rr = int'(r.right);
            if (!model_complete || l >= rr || rr > model_count) begin
                res.idx = '0;
                res.val = '0;
                res.err = 1'b1;
            end else begin
                len = rr - l;
                dep = 0;
                while (dep + 1 < LEVELS && (len >> (dep + 1)) != 0)
                    dep++;
                pos = pick_min_pos(min_pos[dep][l], min_pos[dep][rr - (1 << dep)]);
                res.idx = pos;
                res.val = model_vals[pos];
                res.err = 1'b0;
            end
            expected_minima.insert(expected_minima.size(), res);
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        n_errors++;
    endtask

    // stimulus helpers
    task automatic push_load(logic signed [VW-1:0] v, logic last);
        request_t r;
        r.op    = OP_LOAD;
        r.value = v;
        r.last  = last;
        r.left  = IDX_W'($urandom);
        r.right = CNT_W'($urandom_range(0, N_MAX));
        queued_requests.insert(queued_requests.size(), r);
        n_items++;
    endtask

    task automatic push_query(int l, int rr);
        request_t r;
        r.op    = OP_QUERY;
        r.value = $urandom;
        r.last  = 1'($urandom_range(0, 1));
        r.left  = IDX_W'(l);
        r.right = CNT_W'(rr);
        queued_requests.insert(queued_requests.size(), r);
        n_items++;
    endtask

    function automatic logic signed [VW-1:0] rand_value(int mode);
        case (mode)
            1: begin
                return VW'(int'($urandom_range(0, 6)) - 3);
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic add_set(int n_loads, int nq, int mode);
        int i;
        int l;
        for (i = 0; i < n_loads; i++)
            push_load(rand_value(mode), i == n_loads - 1);
        gen_count = (n_loads > N_MAX) ? N_MAX : n_loads;
        for (i = 0; i < nq; i++) begin
            if ($urandom_range(0, 99) < 85) begin
                l = $urandom_range(0, gen_count - 1);
                push_query(l, $urandom_range(l + 1, gen_count));
            end else begin
                push_query($urandom_range(0, N_MAX - 1), $urandom_range(0, N_MAX));
            end
        end
    endtask

    initial begin
        int c;
        int k;
        int i;
        bit full_done;
        full_done = 1'b0;

        // directed
        push_query(0, 1);
        push_load(32'sh8000_0000, 1'b1);
        push_query(0, 1);
        push_query(0, 0);
        push_query(1, 2);
        push_load(32'sh7fff_ffff, 1'b0);
        push_load(32'sh8000_0000, 1'b0);
        push_load(5, 1'b0);
        push_load(5, 1'b0);
        push_load(0, 1'b1);
        push_query(0, 5);
        push_query(2, 4);
        push_query(0, 1);
        push_query(4, 6);
        push_query(3, 2);
        push_query(N_MAX - 1, N_MAX);
        push_load(7, 1'b0);
        push_query(0, 1);
        push_load(7, 1'b1);
        push_query(0, 2);
        push_query(1, 2);

        // random
        while (n_items < 2000) begin
            if (!full_done && n_items >= 700) begin
                // store full: two extra loads are dropped, last still completes the set
                add_set(N_MAX + 2, 30, 0);
                push_query(0, N_MAX);
                push_query(N_MAX - 1, N_MAX);
                full_done = 1'b1;
            end else begin
                c = $urandom_range(0, 99);
                if (c < 8) begin
                    k = $urandom_range(1, 5);
                    for (i = 0; i < k; i++)
                        push_load(rand_value(0), 1'b0);
                    k = $urandom_range(1, 3);
                    for (i = 0; i < k; i++)
                        push_query($urandom_range(0, N_MAX - 1), $urandom_range(0, N_MAX));
                end else if (c < 12) begin
                    k = $urandom_range(1, 4);
                    for (i = 0; i < k; i++)
                        push_query($urandom_range(0, N_MAX - 1), $urandom_range(0, N_MAX));
                end else begin
                    k = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 256)
                                                    : $urandom_range(1, 40);
                    add_set(k, $urandom_range(0, 30), $urandom_range(0, 2));
                end
            end
        end
        push_query(0, 1);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (n_taken < n_items) @(posedge aclk);
        while (expected_minima.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // driver
    always @(negedge aclk) begin
        request_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !sent_ok) begin
            s_valid <= 1'b1;
        end else if (send_gap > 0) begin
            s_valid <= 1'b0;
            send_gap--;
        end else if (queued_requests.size() > 0) begin
            r = queued_requests.pop_front();
            s_op         <= r.op;
            s_value      <= r.value;
            s_last_value <= r.last;
            s_left       <= r.left;
            s_right      <= r.right;
            s_valid      <= 1'b1;
            send_gap = pick_gap();
        end else begin
            s_valid <= 1'b0;
        end
        sent_ok = 1'b0;
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (!pressure_done && n_taken >= 300) begin
            m_ready <= 1'b0;
            hold_left = 400;
            pressure_done = 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // monitor and predictor
    always @(posedge aclk) begin
        request_t   r;
        range_min_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_minima.size() == 0) begin
                report_mismatch("result with nothing pending");
            end else begin
                want = expected_minima.pop_front();
                if (m_min_index !== want.idx)
                    report_mismatch($sformatf("min_index %0d, want %0d", m_min_index, want.idx));
                if (m_min_value !== want.val)
                    report_mismatch($sformatf("min_value %0d, want %0d", m_min_value, want.val));
                if (m_range_error !== want.err)
                    report_mismatch($sformatf("range_error %0b, want %0b",
                                              m_range_error, want.err));
            end
        end
        if (aresetn && s_valid && s_ready) begin
            r.op    = s_op;
            r.value = s_value;
            r.last  = s_last_value;
            r.left  = s_left;
            r.right = s_right;
            predict_range_min(r);
            n_taken++;
            sent_ok = 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
hdl/strm_pkg.sv
hdl/strm_front.sv
hdl/strm_fifo.sv
hdl/strm_back.sv
hdl/sparse_table_range_min.sv
tb/testbench.sv
